FILE: src/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; every property is sampled on the rising clock edge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// condition that must hold in the cycle after a trigger
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/dbe_pkg.sv
// types, codes and constants of the diffusible buffer euler step block
// no dependencies; used by the divider, datapath, controller and top level
`timescale 1ns / 1ps
`default_nettype none

package dbe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EXP_DEPTH = 256;
  localparam int TAB_SEL_W = $clog2(EXP_DEPTH);
  localparam int TAB_IDX_W = $clog2(EXP_DEPTH + 1);
  localparam int ACC_W     = 48;
  localparam int DVD_W     = 64;
  localparam int DSR_W     = 49;

  typedef logic [32:0] exp_val_t;
  typedef exp_val_t exp_tab_t [0:EXP_DEPTH];

  // shift and subtract quotient, only evaluated at elaboration
  function automatic longint unsigned const_quot(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[62:0], a[j]};
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // exp(-i/depth) in q1.32, taylor series at q1.48, worked out at elaboration
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    for (int i = 0; i <= EXP_DEPTH; i++) begin
      term = 64'd1 << 48;
      pos  = term;
      neg  = 64'd0;
      for (int k = 1; k <= 24; k++) begin
        term = const_quot(term * 64'(i), 64'(k) * 64'(EXP_DEPTH));
        if ((k & 1) == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      tab[i] = 33'(((pos - neg) + (64'd1 << 15)) >> 16);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  // item operations
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_FLUX_IN  = 3'd1,
    OP_FLUX_OUT = 3'd2,
    OP_ACT      = 3'd3,
    OP_REINIT   = 3'd4
  } op_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FORWARD  = 3'd0,
    REG_BACKWARD = 3'd1,
    REG_TOTAL    = 3'd2,
    REG_THICK    = 3'd3,
    REG_STEP     = 3'd4,
    REG_INNER    = 3'd5,
    REG_OUTER    = 3'd6
  } reg_idx_t;

  // datapath micro-operations
  typedef enum logic [4:0] {
    UOP_NOP,
    UOP_FLUX_DIV_IN,
    UOP_FLUX_DIV_OUT,
    UOP_FLUX_MUL,
    UOP_FLUX_ACC,
    UOP_ACT,
    UOP_TICK_MB,
    UOP_TICK_AA,
    UOP_TICK_AB,
    UOP_BRANCH,
    UOP_MS_HI,
    UOP_MS_LO,
    UOP_MS_SUM,
    UOP_EUL_FIN,
    UOP_EXP_SPLIT,
    UOP_EXP_INTERP,
    UOP_EXP_MUL,
    UOP_EXP_SHR,
    UOP_T1_MUL,
    UOP_T1_ST,
    UOP_RAT_LD,
    UOP_EXP_FIN,
    UOP_REI_MUL,
    UOP_REI_CHK,
    UOP_REI_DIV,
    UOP_REI_FIN,
    UOP_COMMIT
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic b_zero;
    logic kb_zero;
    logic n_zero;
    logic x_zero;
    logic out_full;
  } status_t;

endpackage

`default_nettype wire

FILE: src/dbe_if.sv
// valid/ready channel interfaces for input items and results
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface dbe_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] concentration;
  logic [31:0] neighbor_thickness;
  modport source (output valid, operation, concentration, neighbor_thickness, input ready);
  modport sink (input valid, operation, concentration, neighbor_thickness, output ready);
endinterface

interface dbe_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] free_level;
  logic [31:0] bound_level;
  modport source (output valid, free_level, bound_level, input ready);
  modport sink (input valid, free_level, bound_level, output ready);
endinterface

`default_nettype wire

FILE: src/dbe_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on dbe_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dbe_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dbe_pkg::DVD_W-1:0]   dividend,
  input  logic [dbe_pkg::DSR_W-1:0]   divisor,
  output logic                        busy,
  output logic [dbe_pkg::DVD_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(dbe_pkg::DVD_W + 1);

  logic [dbe_pkg::DSR_W-1:0] rem;
  logic [dbe_pkg::DSR_W-1:0] dsr;
  logic [CNT_W-1:0]          cnt;
  logic [dbe_pkg::DSR_W:0]   rem_sh;
  logic [dbe_pkg::DSR_W:0]   rem_sub;
  logic                      ge;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh  = {rem, quotient[dbe_pkg::DVD_W-1]};
    ge      = rem_sh >= {1'b0, dsr};
    rem_sub = rem_sh - {1'b0, dsr};
  end

  // iteration registers; the quotient shifts in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= CNT_W'(dbe_pkg::DVD_W);
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= ge ? rem_sub[dbe_pkg::DSR_W-1:0] : rem_sh[dbe_pkg::DSR_W-1:0];
      quotient <= {quotient[dbe_pkg::DVD_W-2:0], ge};
      cnt      <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_div_start_busy, clk, rst, start, busy)

endmodule

`default_nettype wire

FILE: src/dbe_datapath.sv
// datapath: registers, shared 33x33 multiplier, exp table, divider, result register
// depends on dbe_pkg, dbe_divider and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dbe_datapath (
  input  logic             clk,
  input  logic             rst,
  input  dbe_pkg::cmd_t    cmd,
  output dbe_pkg::status_t status,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic [31:0]      concentration,
  input  logic [31:0]      neighbor_thickness,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [31:0]      free_level,
  output logic [31:0]      bound_level
);

  localparam int AW = dbe_pkg::ACC_W;
  localparam int TI = dbe_pkg::TAB_IDX_W;
  localparam int TS = dbe_pkg::TAB_SEL_W;

  // configuration
  logic [31:0] kf, kb, total, thick, dt, cin, cout;
  // block state
  logic [31:0]   free, bound, act;
  logic [AW-1:0] acc_a, acc_b;
  // scratch
  logic [31:0]   conc_q, nthick_q, coup, tsum;
  logic [65:0]   prod;
  logic [80:0]   macc;
  logic [AW-1:0] ma, mres;
  logic [32:0]   mb, xv;
  logic [5:0]    ncnt;
  logic [TS-1:0] tidx;
  logic          nbig;
  logic [63:0]   ak;
  logic [48:0]   nfree;

  // divider link
  logic                            div_start, div_busy;
  logic [dbe_pkg::DVD_W-1:0]       div_dvd, div_quo;
  logic [dbe_pkg::DSR_W-1:0]       div_dsr;

  // combinational helpers
  logic [32:0]   mul_a, mul_b;
  logic          mul_en;
  logic [31:0]   coup_sat, fr_new;
  logic [AW-1:0] ratio_sat, a_sat, b_sat;
  logic [49:0]   add_b_val;
  logic [50:0]   sum_a, sum_b;
  logic [31:0]   n_hi;
  logic [15:0]   frac, rr;
  logic [TS-1:0] idx_w;
  logic [32:0]   tab_lo, tab_hi, tab_i, diff, e1;
  logic [80:0]   msum;

  dbe_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // saturation, table reads and accumulator adds
  always_comb begin
    coup_sat  = (|div_quo[63:32]) ? '1 : div_quo[31:0];
    ratio_sat = (|div_quo[63:AW]) ? '1 : div_quo[AW-1:0];
    n_hi      = mres[AW-1:16];
    frac      = mres[15:0];
    idx_w     = frac[15 -: TS];
    rr        = frac << TS;
    tab_lo    = dbe_pkg::EXP_TAB[{1'b0, idx_w}];
    tab_hi    = dbe_pkg::EXP_TAB[{1'b0, idx_w} + TI'(1)];
    tab_i     = dbe_pkg::EXP_TAB[{1'b0, tidx}];
    e1        = dbe_pkg::EXP_TAB[dbe_pkg::EXP_DEPTH];
    diff      = tab_lo - tab_hi;
    add_b_val = (cmd.uop == dbe_pkg::UOP_FLUX_ACC) ? 50'(coup) : prod[65:16];
    sum_a     = 51'(acc_a) + 51'(prod[65:16]);
    sum_b     = 51'(acc_b) + 51'(add_b_val);
    a_sat     = (|sum_a[50:AW]) ? '1 : sum_a[AW-1:0];
    b_sat     = (|sum_b[50:AW]) ? '1 : sum_b[AW-1:0];
    msum      = macc + 81'(prod[64:0]);
    fr_new    = (nfree > 49'(total)) ? total : nfree[31:0];
  end

  // multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (cmd.uop)
      dbe_pkg::UOP_FLUX_MUL:  begin mul_a = 33'(coup_sat); mul_b = 33'(conc_q); end
      dbe_pkg::UOP_TICK_MB:   begin mul_a = 33'(kb);       mul_b = 33'(bound);  end
      dbe_pkg::UOP_TICK_AA:   begin mul_a = 33'(kf);       mul_b = 33'(act);    end
      dbe_pkg::UOP_MS_HI:     begin mul_a = 33'(ma[AW-1:16]); mul_b = mb;       end
      dbe_pkg::UOP_MS_LO:     begin mul_a = 33'(ma[15:0]); mul_b = mb;          end
      dbe_pkg::UOP_EXP_SPLIT: begin mul_a = diff;          mul_b = 33'(rr);     end
      dbe_pkg::UOP_EXP_MUL:   begin mul_a = xv;            mul_b = e1;          end
      dbe_pkg::UOP_T1_MUL:    begin mul_a = 33'(free);     mul_b = xv;          end
      dbe_pkg::UOP_REI_MUL:   begin mul_a = 33'(act);      mul_b = 33'(kf);     end
      dbe_pkg::UOP_REI_CHK:   begin mul_a = 33'(total);    mul_b = 33'(kb);     end
      default:                mul_en = 1'b0;
    endcase
  end

  // divider operand select
  always_comb begin
    div_start = 1'b1;
    div_dvd   = '0;
    div_dsr   = '0;
    unique case (cmd.uop)
      dbe_pkg::UOP_FLUX_DIV_IN: begin
        div_dvd = 64'(cin) << dbe_pkg::FRAC_BITS;
        div_dsr = 49'(thick) + 49'(nthick_q);
      end
      dbe_pkg::UOP_FLUX_DIV_OUT: begin
        div_dvd = 64'(cout) << dbe_pkg::FRAC_BITS;
        div_dsr = 49'(thick) + 49'(nthick_q);
      end
      dbe_pkg::UOP_T1_ST: begin
        div_dvd = 64'(acc_a) << dbe_pkg::FRAC_BITS;
        div_dsr = 49'(acc_b);
      end
      dbe_pkg::UOP_REI_DIV: begin
        div_dvd = prod[63:0];
        div_dsr = 49'(kb) + 49'(ak[63:16]);
      end
      default: div_start = 1'b0;
    endcase
  end

  // configuration, block state and result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      kf <= '0; kb <= '0; total <= '0; thick <= '0;
      dt <= '0; cin <= '0; cout <= '0;
      free <= '0; bound <= '0; act <= '0;
      acc_a <= '0; acc_b <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (dbe_pkg::reg_idx_t'(cfg_index))
          dbe_pkg::REG_FORWARD:  kf <= cfg_data;
          dbe_pkg::REG_BACKWARD: kb <= cfg_data;
          dbe_pkg::REG_TOTAL: begin
            total <= cfg_data;
            free  <= cfg_data;
            bound <= '0;
          end
          dbe_pkg::REG_THICK:    thick <= cfg_data;
          dbe_pkg::REG_STEP:     dt <= cfg_data;
          dbe_pkg::REG_INNER:    cin <= cfg_data;
          dbe_pkg::REG_OUTER:    cout <= cfg_data;
          default: ;
        endcase
      end
      unique case (cmd.uop)
        dbe_pkg::UOP_FLUX_ACC: begin
          acc_a <= a_sat;
          acc_b <= b_sat;
        end
        dbe_pkg::UOP_ACT:     act <= conc_q;
        dbe_pkg::UOP_TICK_AA: acc_a <= a_sat;
        dbe_pkg::UOP_TICK_AB: acc_b <= b_sat;
        dbe_pkg::UOP_COMMIT: begin
          free      <= fr_new;
          bound     <= total - fr_new;
          acc_a     <= '0;
          acc_b     <= '0;
          res_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // scratch registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      conc_q   <= concentration;
      nthick_q <= neighbor_thickness;
    end
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    unique case (cmd.uop)
      dbe_pkg::UOP_FLUX_MUL: coup <= coup_sat;
      dbe_pkg::UOP_BRANCH: begin
        ma <= (acc_b == '0) ? acc_a : acc_b;
        mb <= {1'b0, dt};
      end
      dbe_pkg::UOP_MS_LO:  macc <= {prod[64:0], 16'b0};
      dbe_pkg::UOP_MS_SUM: mres <= msum[79:32];
      dbe_pkg::UOP_EUL_FIN: nfree <= 49'(free) + 49'(mres);
      dbe_pkg::UOP_EXP_SPLIT: begin
        tidx <= idx_w;
        nbig <= |n_hi[31:6];
        ncnt <= n_hi[5:0];
      end
      dbe_pkg::UOP_EXP_INTERP: xv <= nbig ? '0 : (tab_i - prod[48:16]);
      dbe_pkg::UOP_EXP_SHR: begin
        xv   <= prod[64:32];
        ncnt <= ncnt - 6'd1;
      end
      dbe_pkg::UOP_T1_ST: tsum <= prod[63:32];
      dbe_pkg::UOP_RAT_LD: begin
        ma <= ratio_sat;
        mb <= 33'h1_0000_0000 - xv;
      end
      dbe_pkg::UOP_EXP_FIN: nfree <= 49'(tsum) + 49'(mres);
      dbe_pkg::UOP_REI_CHK: begin
        ak    <= prod[63:0];
        nfree <= (prod[63:0] == '0) ? 49'(total) : '0;
      end
      dbe_pkg::UOP_REI_FIN: nfree <= (div_quo > 64'(total)) ? 49'(total) : div_quo[48:0];
      dbe_pkg::UOP_COMMIT: begin
        free_level  <= fr_new;
        bound_level <= total - fr_new;
      end
      default: ;
    endcase
  end

  // status towards the controller
  always_comb begin
    status.div_busy = div_busy;
    status.b_zero   = (acc_b == '0);
    status.kb_zero  = (kb == '0);
    status.n_zero   = (ncnt == '0);
    status.x_zero   = (xv == '0);
    status.out_full = res_valid && !res_ready;
  end

  `ASSERT_CLK(a_free_le_total, clk, rst, free <= total)
  `ASSERT_CLK(a_free_bound_sum, clk, rst, ({1'b0, bound} + {1'b0, free}) == {1'b0, total})

endmodule

`default_nettype wire

FILE: src/dbe_ctrl.sv
// controller state machine, sequences micro-operations of the datapath
// depends on dbe_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dbe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       operation,
  output dbe_pkg::cmd_t    cmd,
  input  dbe_pkg::status_t status
);

  typedef enum logic [4:0] {
    S_IDLE, S_FLUX_DIV_IN, S_FLUX_DIV_OUT, S_FLUX_WAIT, S_FLUX_MUL, S_FLUX_ACC,
    S_ACT, S_TICK_MB, S_TICK_AA, S_TICK_AB, S_BRANCH, S_MS_HI, S_MS_LO, S_MS_SUM,
    S_EUL_FIN, S_EXP_SPLIT, S_EXP_INTERP, S_EXP_LOOP, S_EXP_MUL, S_EXP_SHR,
    S_T1_MUL, S_T1_ST, S_RAT_WAIT, S_RAT_LD, S_EXP_FIN, S_REI_MUL, S_REI_CHK,
    S_REI_DIV, S_REI_WAIT, S_REI_FIN, S_COMMIT
  } state_t;

  // where the shared q1.32 multiply sequence returns to
  typedef enum logic [1:0] {RET_EUL, RET_EXP, RET_RAT} ret_t;

  state_t state;
  ret_t   ret;

  assign in_ready = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= RET_EUL;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (dbe_pkg::op_t'(operation))
              dbe_pkg::OP_TICK:     state <= S_TICK_MB;
              dbe_pkg::OP_FLUX_IN:  state <= S_FLUX_DIV_IN;
              dbe_pkg::OP_FLUX_OUT: state <= S_FLUX_DIV_OUT;
              dbe_pkg::OP_ACT:      state <= S_ACT;
              dbe_pkg::OP_REINIT:   state <= S_REI_MUL;
              default:              state <= S_IDLE;
            endcase
          end
        end
        S_FLUX_DIV_IN, S_FLUX_DIV_OUT: state <= S_FLUX_WAIT;
        S_FLUX_WAIT: if (!status.div_busy) state <= S_FLUX_MUL;
        S_FLUX_MUL:  state <= S_FLUX_ACC;
        S_FLUX_ACC:  state <= S_IDLE;
        S_ACT:       state <= S_IDLE;
        S_TICK_MB:   state <= S_TICK_AA;
        S_TICK_AA:   state <= S_TICK_AB;
        S_TICK_AB:   state <= S_BRANCH;
        S_BRANCH: begin
          ret   <= status.b_zero ? RET_EUL : RET_EXP;
          state <= S_MS_HI;
        end
        S_MS_HI: state <= S_MS_LO;
        S_MS_LO: state <= S_MS_SUM;
        S_MS_SUM: begin
          unique case (ret)
            RET_EUL: state <= S_EUL_FIN;
            RET_EXP: state <= S_EXP_SPLIT;
            RET_RAT: state <= S_EXP_FIN;
            default: state <= S_EUL_FIN;
          endcase
        end
        S_EUL_FIN:    state <= S_COMMIT;
        S_EXP_SPLIT:  state <= S_EXP_INTERP;
        S_EXP_INTERP: state <= S_EXP_LOOP;
        S_EXP_LOOP:   state <= (status.n_zero || status.x_zero) ? S_T1_MUL : S_EXP_MUL;
        S_EXP_MUL:    state <= S_EXP_SHR;
        S_EXP_SHR:    state <= S_EXP_LOOP;
        S_T1_MUL:     state <= S_T1_ST;
        S_T1_ST:      state <= S_RAT_WAIT;
        S_RAT_WAIT:   if (!status.div_busy) state <= S_RAT_LD;
        S_RAT_LD: begin
          ret   <= RET_RAT;
          state <= S_MS_HI;
        end
        S_EXP_FIN:  state <= S_COMMIT;
        S_REI_MUL:  state <= S_REI_CHK;
        S_REI_CHK:  state <= status.kb_zero ? S_COMMIT : S_REI_DIV;
        S_REI_DIV:  state <= S_REI_WAIT;
        S_REI_WAIT: if (!status.div_busy) state <= S_REI_FIN;
        S_REI_FIN:  state <= S_COMMIT;
        S_COMMIT:   if (!status.out_full) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

  // micro-operation for the current state, item load on an accepted transaction
  always_comb begin
    cmd.load = in_valid && in_ready;
    unique case (state)
      S_FLUX_DIV_IN:  cmd.uop = dbe_pkg::UOP_FLUX_DIV_IN;
      S_FLUX_DIV_OUT: cmd.uop = dbe_pkg::UOP_FLUX_DIV_OUT;
      S_FLUX_MUL:     cmd.uop = dbe_pkg::UOP_FLUX_MUL;
      S_FLUX_ACC:     cmd.uop = dbe_pkg::UOP_FLUX_ACC;
      S_ACT:          cmd.uop = dbe_pkg::UOP_ACT;
      S_TICK_MB:      cmd.uop = dbe_pkg::UOP_TICK_MB;
      S_TICK_AA:      cmd.uop = dbe_pkg::UOP_TICK_AA;
      S_TICK_AB:      cmd.uop = dbe_pkg::UOP_TICK_AB;
      S_BRANCH:       cmd.uop = dbe_pkg::UOP_BRANCH;
      S_MS_HI:        cmd.uop = dbe_pkg::UOP_MS_HI;
      S_MS_LO:        cmd.uop = dbe_pkg::UOP_MS_LO;
      S_MS_SUM:       cmd.uop = dbe_pkg::UOP_MS_SUM;
      S_EUL_FIN:      cmd.uop = dbe_pkg::UOP_EUL_FIN;
      S_EXP_SPLIT:    cmd.uop = dbe_pkg::UOP_EXP_SPLIT;
      S_EXP_INTERP:   cmd.uop = dbe_pkg::UOP_EXP_INTERP;
      S_EXP_MUL:      cmd.uop = dbe_pkg::UOP_EXP_MUL;
      S_EXP_SHR:      cmd.uop = dbe_pkg::UOP_EXP_SHR;
      S_T1_MUL:       cmd.uop = dbe_pkg::UOP_T1_MUL;
      S_T1_ST:        cmd.uop = dbe_pkg::UOP_T1_ST;
      S_RAT_LD:       cmd.uop = dbe_pkg::UOP_RAT_LD;
      S_EXP_FIN:      cmd.uop = dbe_pkg::UOP_EXP_FIN;
      S_REI_MUL:      cmd.uop = dbe_pkg::UOP_REI_MUL;
      S_REI_CHK:      cmd.uop = dbe_pkg::UOP_REI_CHK;
      S_REI_DIV:      cmd.uop = dbe_pkg::UOP_REI_DIV;
      S_REI_FIN:      cmd.uop = dbe_pkg::UOP_REI_FIN;
      S_COMMIT:       cmd.uop = status.out_full ? dbe_pkg::UOP_NOP : dbe_pkg::UOP_COMMIT;
      default:        cmd.uop = dbe_pkg::UOP_NOP;
    endcase
  end

  `ASSERT_CLK(a_div_busy_waits, clk, rst,
    !status.div_busy || state == S_FLUX_WAIT || state == S_RAT_WAIT || state == S_REI_WAIT)

endmodule

`default_nettype wire

FILE: src/diffusible_buffer_exp_euler_step.sv
// top level of the diffusible buffer shell, exponential euler step
// depends on dbe_pkg, dbe_if, dbe_ctrl and dbe_datapath
//
//  channel  | direction | transaction                     | payload
//  item     | in        | valid & ready                   | operation, concentration,
//           |           |                                 | neighbor_thickness
//  result   | out       | valid & ready                   | free_level, bound_level
//  cfg      | in        | cfg_we high                     | cfg_index, cfg_data
//
// one item at a time: activation, flux, reinit (which skips the divide when kb is zero) and tick,
// which takes the euler path when B is zero and else the exp path; the exp path repeats the
// exp(-1) multiply for the integer part of B*dt; flux, reinit and exp wait on the divider
// a finished result sits in the output register while the next item is taken
// a result stalls the controller only when the previous one has not been taken yet
// synchronous reset clears configuration, block state, accumulators and control state; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module diffusible_buffer_exp_euler_step (
  input  logic                clk,
  input  logic                rst,
  dbe_item_if.sink            item,
  dbe_result_if.source        result,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  dbe_pkg::cmd_t    cmd;
  dbe_pkg::status_t status;

  dbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .operation (item.operation),
    .cmd       (cmd),
    .status    (status)
  );

  dbe_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .concentration      (item.concentration),
    .neighbor_thickness (item.neighbor_thickness),
    .res_valid          (result.valid),
    .res_ready          (result.ready),
    .free_level         (result.free_level),
    .bound_level        (result.bound_level)
  );

endmodule

`default_nettype wire
